@@ hw/rtl/tle_pkg.sv @@
// tle_pkg: shared types and fixed field widths for the tour length evaluator.
// Used by tle_sum_stage and tour_length_evaluator_core.
`timescale 1ns / 1ps

package tle_pkg;

    localparam int CITY_FIELD_W = 6;
    localparam int CITY_FIELD_VALUES = 64;
    localparam int DIST_FIELD_W = 32;
    localparam int SUM_BITS = 38;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_VISIT = 1'b1
    } t_kind;

    typedef struct packed {
        logic start;
        logic last;
    } t_s1_ctl;

endpackage

@@ hw/rtl/tle_dist_store.sv @@
// tle_dist_store: city-to-city distance memory, one write port and two
// registered read ports (step entry and closing entry). No package use.
`timescale 1ns / 1ps

module tle_dist_store #(
    parameter int CITY_BITS = 6,
    parameter int DIST_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [2*CITY_BITS-1:0] i_waddr,
    input  logic [DIST_BITS-1:0]   i_wdata,
    input  logic                   i_re,
    input  logic [2*CITY_BITS-1:0] i_raddr_step,
    input  logic [2*CITY_BITS-1:0] i_raddr_close,
    output logic [DIST_BITS-1:0]   o_rd_step,
    output logic [DIST_BITS-1:0]   o_rd_close
);

    localparam int MEM_DEPTH = 1 << (2 * CITY_BITS);

    logic [DIST_BITS-1:0] r_mem [MEM_DEPTH];
    logic [DIST_BITS-1:0] r_rd_step;
    logic [DIST_BITS-1:0] r_rd_close;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_step  <= r_mem[i_raddr_step];
            r_rd_close <= r_mem[i_raddr_close];
        end
    end

    assign o_rd_step  = r_rd_step;
    assign o_rd_close = r_rd_close;

endmodule

@@ hw/rtl/tle_sum_stage.sv @@
// tle_sum_stage: pairs the step and closing distances, accumulates the tour
// sum with saturation and holds the result register. Uses tle_pkg.
`timescale 1ns / 1ps

module tle_sum_stage #(
    parameter int DIST_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s1_valid,
    input  tle_pkg::t_s1_ctl                  i_s1_ctl,
    input  logic [DIST_BITS-1:0]              i_rd_step,
    input  logic [DIST_BITS-1:0]              i_rd_close,
    output logic                              o_s1_take,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [tle_pkg::SUM_BITS-1:0]      o_tour_length
);

    localparam int PAIR_W = DIST_BITS + 1;
    localparam int ACC_W  = ((tle_pkg::SUM_BITS > PAIR_W) ? tle_pkg::SUM_BITS : PAIR_W) + 1;

    logic                          r_s2_valid;
    logic                          r_s2_start;
    logic                          r_s2_last;
    logic [PAIR_W-1:0]             r_s2_pair;
    logic [tle_pkg::SUM_BITS-1:0]  r_sum;
    logic [tle_pkg::SUM_BITS-1:0]  n_sum;
    logic                          r_out_valid;
    logic [tle_pkg::SUM_BITS-1:0]  r_tour_length;

    logic                          out_free;
    logic                          s2_go;
    logic                          s2_free;
    logic [DIST_BITS-1:0]          step_term;
    logic [DIST_BITS-1:0]          close_term;
    logic [ACC_W-1:0]              acc_base;
    logic [ACC_W-1:0]              acc_total;

    assign out_free  = !r_out_valid || !i_stall;
    assign s2_go     = r_s2_valid && (!r_s2_last || out_free);
    assign s2_free   = !r_s2_valid || s2_go;
    assign o_s1_take = s2_free;

    assign step_term  = i_s1_ctl.start ? '0 : i_rd_step;
    assign close_term = i_s1_ctl.last ? i_rd_close : '0;

    // saturate once on the combined step: both terms are non-negative
    always_comb begin
        acc_base  = r_s2_start ? '0 : ACC_W'(r_sum);
        acc_total = acc_base + ACC_W'(r_s2_pair);
        if (acc_total[ACC_W-1:tle_pkg::SUM_BITS] != '0) begin
            n_sum = {tle_pkg::SUM_BITS{1'b1}};
        end else begin
            n_sum = acc_total[tle_pkg::SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_free) begin
                r_s2_valid <= i_s1_valid;
            end
            if (s2_go) begin
                r_sum <= n_sum;
            end
            if (s2_go && r_s2_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && i_s1_valid) begin
            r_s2_start <= i_s1_ctl.start;
            r_s2_last  <= i_s1_ctl.last;
            r_s2_pair  <= PAIR_W'(step_term) + PAIR_W'(close_term);
        end
        if (s2_go && r_s2_last) begin
            r_tour_length <= n_sum;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_tour_length = r_tour_length;

endmodule

@@ hw/rtl/tour_length_evaluator_core.sv @@
// tour_length_evaluator_core: top level; takes load and visit transfers,
// tracks tour state and drives tle_dist_store and tle_sum_stage. Uses tle_pkg.
//
//   channel  | valid   | stall   | payload
//   ---------+---------+---------+----------------------------------------------
//   input    | i_valid | o_stall | i_kind i_from_city i_to_city i_distance
//            |         |         | i_city i_last_city
//   output   | o_valid | i_stall | o_tour_length
//
// One transfer per cycle while o_stall is low. After its last city a result passes
// the registered store read, the pair add and the accumulate add. Reset clears
// tour state and pipeline valids, not the store. A stalled result holds only
// a last-city item in the pair stage, and so the items behind it; others flow.
`timescale 1ns / 1ps

module tour_length_evaluator_core #(
    parameter int MAX_CITIES = 64,
    parameter int DIST_BITS  = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_kind,
    input  logic [tle_pkg::CITY_FIELD_W-1:0]      i_from_city,
    input  logic [tle_pkg::CITY_FIELD_W-1:0]      i_to_city,
    input  logic [tle_pkg::DIST_FIELD_W-1:0]      i_distance,
    input  logic [tle_pkg::CITY_FIELD_W-1:0]      i_city,
    input  logic                                  i_last_city,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [tle_pkg::SUM_BITS-1:0]          o_tour_length
);

    localparam int CITY_BITS = $clog2(MAX_CITIES);

    logic [CITY_BITS-1:0]   city_mod [tle_pkg::CITY_FIELD_VALUES];

    logic                   r_open;
    logic [CITY_BITS-1:0]   r_first;
    logic [CITY_BITS-1:0]   r_prev;
    logic                   r_s1_valid;
    tle_pkg::t_s1_ctl       r_s1_ctl;

    logic                   accept;
    logic                   accept_load;
    logic                   accept_visit;
    logic                   s1_take;
    logic                   s1_free;
    logic                   tour_start;
    logic [CITY_BITS-1:0]   cur_city;
    logic [CITY_BITS-1:0]   row_close;
    logic [DIST_BITS-1:0]   rd_step;
    logic [DIST_BITS-1:0]   rd_close;

    for (genvar g = 0; g < tle_pkg::CITY_FIELD_VALUES; g++) begin : g_city_mod
        assign city_mod[g] = CITY_BITS'(g % MAX_CITIES);
    end

    assign s1_free      = !r_s1_valid || s1_take;
    assign o_stall      = !s1_free;
    assign accept       = i_valid && s1_free;
    assign accept_load  = accept && (i_kind == tle_pkg::KIND_LOAD);
    assign accept_visit = accept && (i_kind == tle_pkg::KIND_VISIT);

    assign tour_start = !r_open;
    assign cur_city   = city_mod[i_city];
    assign row_close  = tour_start ? cur_city : r_first;

    tle_dist_store #(
        .CITY_BITS (CITY_BITS),
        .DIST_BITS (DIST_BITS)
    ) u_store (
        .i_clk         (i_clk),
        .i_we          (accept_load),
        .i_waddr       ({city_mod[i_from_city], city_mod[i_to_city]}),
        .i_wdata       (DIST_BITS'(i_distance)),
        .i_re          (accept_visit),
        .i_raddr_step  ({r_prev, cur_city}),
        .i_raddr_close ({row_close, cur_city}),
        .o_rd_step     (rd_step),
        .o_rd_close    (rd_close)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_first    <= '0;
            r_prev     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept_visit) begin
                r_open  <= !i_last_city;
                r_first <= row_close;
                r_prev  <= cur_city;
            end
            if (s1_free) begin
                r_s1_valid <= accept_visit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_visit) begin
            r_s1_ctl.start <= tour_start;
            r_s1_ctl.last  <= i_last_city;
        end
    end

    tle_sum_stage #(
        .DIST_BITS (DIST_BITS)
    ) u_sum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s1_valid    (r_s1_valid),
        .i_s1_ctl      (r_s1_ctl),
        .i_rd_step     (rd_step),
        .i_rd_close    (rd_close),
        .o_s1_take     (s1_take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tour_length (o_tour_length)
    );

endmodule
